FILE: hdl/plane_sweep_rect_join_macros.svh
// Assertion macros for the plane sweep rectangle join.
// Included by the top level; depends on nothing else.
`ifndef PLANE_SWEEP_RECT_JOIN_MACROS_SVH
`define PLANE_SWEEP_RECT_JOIN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSRJ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PSRJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSRJ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PSRJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/psrj_pkg.sv
// Shared types and constants of the plane sweep rectangle join.
// No dependencies; used by psrj_cell, psrj_window and the top level.
package psrj_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int COORD_W      = 32;
    localparam int ID_W         = 32;
    localparam int CNT_W        = $clog2(MAX_RESULTS);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ID_W-1:0]           id_t;

    localparam logic OP_RECT  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    // broadcast to every cell of one window
    typedef struct packed {
        logic   clear;
        logic   eval;
        logic   own;
        coord_t x_low;
        coord_t y_low;
        coord_t x_high;
        id_t    rect_id;
        coord_t y_high;
    } win_ctrl_t;

endpackage

FILE: hdl/psrj_cell.sv
// One window cell: a stored rectangle with its occupied bit.
// Depends on psrj_pkg. Passes the free-slot token on to the next cell.
module psrj_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  psrj_pkg::win_ctrl_t ctrl,
    input  logic                token_in,
    output logic                token_out,
    output logic                match,
    output psrj_pkg::id_t       cell_id
);

    logic             occ_reg, occ_next;
    psrj_pkg::coord_t xl_reg, xl_next;
    psrj_pkg::coord_t xh_reg, xh_next;
    psrj_pkg::coord_t yh_reg, yh_next;
    psrj_pkg::id_t    id_reg, id_next;

    logic stale;
    logic free_slot;
    logic take;
    logic hit_x;

    always_comb
    begin
        stale     = occ_reg && ($signed(yh_reg) < $signed(ctrl.y_low));
        free_slot = !occ_reg || stale;
        take      = ctrl.eval && ctrl.own && token_in && free_slot;
        token_out = token_in && !free_slot;
        hit_x     = (($signed(ctrl.x_low) <= $signed(xl_reg))
                      && ($signed(xl_reg) <= $signed(ctrl.x_high)))
                 || (($signed(xl_reg) <= $signed(ctrl.x_low))
                      && ($signed(ctrl.x_low) <= $signed(xh_reg)));
        match     = occ_reg && ($signed(yh_reg) >= $signed(ctrl.y_low)) && hit_x;
        cell_id   = id_reg;
    end

    always_comb
    begin
        occ_next = occ_reg;
        xl_next  = xl_reg;
        xh_next  = xh_reg;
        yh_next  = yh_reg;
        id_next  = id_reg;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.eval)
        begin
            occ_next = take || (occ_reg && !stale);
        end
        if (take)
        begin
            xl_next = ctrl.x_low;
            xh_next = ctrl.x_high;
            yh_next = ctrl.y_high;
            id_next = ctrl.rect_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xl_reg <= xl_next;
        xh_reg <= xh_next;
        yh_reg <= yh_next;
        id_reg <= id_next;
    end

endmodule

FILE: hdl/psrj_window.sv
// One color window: a row of psrj_cell with the free-slot token chain.
// Depends on psrj_pkg and psrj_cell.
module psrj_window (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psrj_pkg::win_ctrl_t                  ctrl,
    output logic [psrj_pkg::WINDOW_DEPTH-1:0]    match_vec,
    output psrj_pkg::id_t                        cell_ids [psrj_pkg::WINDOW_DEPTH],
    output logic                                 full
);

    logic [psrj_pkg::WINDOW_DEPTH:0] token;

    assign token[0] = 1'b1;

    for (genvar i = 0; i < psrj_pkg::WINDOW_DEPTH; i++)
    begin : g_cell
        psrj_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .token_in  (token[i]),
            .token_out (token[i+1]),
            .match     (match_vec[i]),
            .cell_id   (cell_ids[i])
        );
    end

    // token reaching the end: no free cell took the insert
    assign full = token[psrj_pkg::WINDOW_DEPTH];

endmodule

FILE: hdl/plane_sweep_rect_join.sv
// Plane sweep rectangle join, top level. An item is taken only in idle, then
// passes an evaluate state and an emit state that registers one result beat
// a cycle unless result_stall holds it; the next item waits for the last beat.
// Async active-low reset empties both windows and idles the control; cell
// payloads are not reset.
`include "plane_sweep_rect_join_macros.svh"
module plane_sweep_rect_join (
    input  logic                   clk,
    input  logic                   rst_n,
    // item channel
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   operation,
    input  logic                   is_blue,
    input  psrj_pkg::coord_t       x_low,
    input  psrj_pkg::coord_t       y_low,
    input  psrj_pkg::coord_t       x_high,
    input  psrj_pkg::coord_t       y_high,
    input  psrj_pkg::id_t          rect_id,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   pair_valid,
    output psrj_pkg::id_t          red_id,
    output psrj_pkg::id_t          blue_id,
    output logic                   last_result,
    output logic                   overflow
);

    localparam int DEPTH = psrj_pkg::WINDOW_DEPTH;

    psrj_pkg::state_t state_reg, state_next;

    // item held for the whole evaluate/emit sequence
    logic             op_reg, op_next;
    logic             blue_reg, blue_next;
    psrj_pkg::coord_t xl_reg, xl_next;
    psrj_pkg::coord_t yl_reg, yl_next;
    psrj_pkg::coord_t xh_reg, xh_next;
    psrj_pkg::coord_t yh_reg, yh_next;
    psrj_pkg::id_t    id_reg, id_next;

    // pending matches, ascending cell index
    logic [DEPTH-1:0]           hit_reg, hit_next;
    logic                       ovf_reg, ovf_next;
    logic [psrj_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // result beat register
    logic          rv_reg, rv_next;
    logic          pv_reg, pv_next;
    psrj_pkg::id_t rid_reg, rid_next;
    psrj_pkg::id_t bid_reg, bid_next;
    logic          last_reg, last_next;
    logic          rovf_reg, rovf_next;

    psrj_pkg::win_ctrl_t red_ctrl, blue_ctrl;
    logic [DEPTH-1:0]    red_match, blue_match;
    psrj_pkg::id_t       red_ids  [DEPTH];
    psrj_pkg::id_t       blue_ids [DEPTH];
    logic                red_full, blue_full;

    // FSM outputs
    logic item_take;
    logic eval_go;
    logic emit_go;

    // emit datapath
    logic [DEPTH-1:0] low_bit;
    logic [DEPTH-1:0] hit_rest;
    psrj_pkg::id_t    sel_id;
    logic             has_pair;
    logic             is_last;

    psrj_window u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (red_ctrl),
        .match_vec (red_match),
        .cell_ids  (red_ids),
        .full      (red_full)
    );

    psrj_window u_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (blue_ctrl),
        .match_vec (blue_match),
        .cell_ids  (blue_ids),
        .full      (blue_full)
    );

    // Both windows free stale cells in the evaluate cycle; only the own window
    // takes the insert. Matches come from the other window's pre-insert state.
    always_comb
    begin
        red_ctrl.clear   = eval_go && (op_reg == psrj_pkg::OP_CLEAR);
        red_ctrl.eval    = eval_go && (op_reg == psrj_pkg::OP_RECT);
        red_ctrl.own     = !blue_reg;
        red_ctrl.x_low   = xl_reg;
        red_ctrl.y_low   = yl_reg;
        red_ctrl.x_high  = xh_reg;
        red_ctrl.y_high  = yh_reg;
        red_ctrl.rect_id = id_reg;
        blue_ctrl        = red_ctrl;
        blue_ctrl.own    = blue_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psrj_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = psrj_pkg::ST_EVAL;
                end
            end
            psrj_pkg::ST_EVAL:
            begin
                state_next = psrj_pkg::ST_EMIT;
            end
            psrj_pkg::ST_EMIT:
            begin
                if (emit_go && is_last)
                begin
                    state_next = psrj_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psrj_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        item_stall = 1'b1;
        eval_go    = 1'b0;
        emit_go    = 1'b0;
        case (state_reg)
            psrj_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            psrj_pkg::ST_EVAL:
            begin
                eval_go = 1'b1;
            end
            psrj_pkg::ST_EMIT:
            begin
                emit_go = !rv_reg || !result_stall;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
        item_take = item_valid && !item_stall;
    end

    // lowest pending match, id from the other window
    always_comb
    begin
        low_bit  = hit_reg & (~hit_reg + {{(DEPTH-1){1'b0}}, 1'b1});
        hit_rest = hit_reg & ~low_bit;
        has_pair = (hit_reg != '0);
        sel_id   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_id = sel_id | ({psrj_pkg::ID_W{low_bit[i]}}
                               & (blue_reg ? red_ids[i] : blue_ids[i]));
        end
        // cap at MAX_RESULTS beats per item
        is_last = !has_pair || (hit_rest == '0)
               || (cnt_reg == psrj_pkg::CNT_W'(psrj_pkg::MAX_RESULTS - 1));
    end

    // item, match and result registers
    always_comb
    begin
        op_next   = op_reg;
        blue_next = blue_reg;
        xl_next   = xl_reg;
        yl_next   = yl_reg;
        xh_next   = xh_reg;
        yh_next   = yh_reg;
        id_next   = id_reg;
        hit_next  = hit_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rv_next   = rv_reg && result_stall;
        pv_next   = pv_reg;
        rid_next  = rid_reg;
        bid_next  = bid_reg;
        last_next = last_reg;
        rovf_next = rovf_reg;
        if (item_take)
        begin
            op_next   = operation;
            blue_next = is_blue;
            xl_next   = x_low;
            yl_next   = y_low;
            xh_next   = x_high;
            yh_next   = y_high;
            id_next   = rect_id;
        end
        if (eval_go)
        begin
            cnt_next = '0;
            if (op_reg == psrj_pkg::OP_CLEAR)
            begin
                hit_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                hit_next = blue_reg ? red_match : blue_match;
                ovf_next = blue_reg ? blue_full : red_full;
            end
        end
        if (emit_go)
        begin
            hit_next  = hit_rest;
            cnt_next  = cnt_reg + psrj_pkg::CNT_W'(1);
            rv_next   = 1'b1;
            pv_next   = has_pair;
            rid_next  = has_pair ? (blue_reg ? sel_id : id_reg) : '0;
            bid_next  = has_pair ? (blue_reg ? id_reg : sel_id) : '0;
            last_next = is_last;
            rovf_next = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psrj_pkg::ST_IDLE;
            rv_reg    <= 1'b0;
            cnt_reg   <= '0;
            hit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        blue_reg <= blue_next;
        xl_reg   <= xl_next;
        yl_reg   <= yl_next;
        xh_reg   <= xh_next;
        yh_reg   <= yh_next;
        id_reg   <= id_next;
        ovf_reg  <= ovf_next;
        pv_reg   <= pv_next;
        rid_reg  <= rid_next;
        bid_reg  <= bid_next;
        last_reg <= last_next;
        rovf_reg <= rovf_next;
    end

    assign result_valid = rv_reg;
    assign pair_valid   = pv_reg;
    assign red_id       = rid_reg;
    assign blue_id      = bid_reg;
    assign last_result  = last_reg;
    assign overflow     = rovf_reg;

    // a beat without a pair is always the only beat of its item
    `PSRJ_ASSERT_IMPL(a_nopair_last, clk, rst_n, result_valid && !pair_valid, last_result, "pairless beat not last")
    // a stalled beat stays valid and keeps its ids
    `PSRJ_ASSERT_NEXT(a_stall_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(red_id) && $stable(blue_id), "stalled beat changed")
    // an accepted item keeps the block busy in the next cycle
    `PSRJ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item_valid && !item_stall, item_stall, "second item taken back to back")

endmodule
